### design/bwr_pkg.sv
// ----------------------------------------------------------------------------
// bwr_pkg
// Shared types, constants and helpers for the bit width repacker
// ----------------------------------------------------------------------------
package bwr_pkg;

    localparam int MaxBytes     = 7;
    localparam int CfgDataWidth = 5;

    localparam logic       ModeReset      = 1'b0;
    localparam logic [4:0] FieldBitsReset = 5'd17;
    localparam logic [2:0] PadBytesReset  = 3'd1;

    localparam logic [4:0] FieldBitsMin = 5'd8;
    localparam logic [4:0] FieldBitsMax = 5'd24;
    localparam logic [2:0] PadBytesMax  = 3'd4;

    localparam logic ModeExpand   = 1'b0;
    localparam logic ModeCompress = 1'b1;

    typedef enum logic [1:0] {
        RegMode      = 2'd0,
        RegFieldBits = 2'd1,
        RegPadBytes  = 2'd2
    } bwr_reg_idx_t;

    typedef struct packed {
        logic       mode;
        logic [4:0] field_bits;
        logic [2:0] pad_bytes;
    } bwr_cfg_t;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       start_req;
    } bwr_item_t;

    typedef logic [MaxBytes-1:0][7:0] bwr_bytes_t;

    typedef struct packed {
        bwr_bytes_t bytes;
        logic [2:0] count;
    } bwr_result_t;

    function automatic logic [7:0] pick_byte(input logic [31:0] w, input logic [2:0] idx);
        logic [7:0] b;
        case (idx)
            3'd0:    b = w[7:0];
            3'd1:    b = w[15:8];
            3'd2:    b = w[23:16];
            3'd3:    b = w[31:24];
            default: b = 8'h00;
        endcase
        return b;
    endfunction

endpackage

### design/bwr_input_stage.sv
// ----------------------------------------------------------------------------
// bwr_input_stage
// Input register holding one accepted item until the core takes it
// ----------------------------------------------------------------------------
module bwr_input_stage
    import bwr_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_ready,
    input  logic [7:0] data_byte,
    input  logic      start_req,
    input  logic      take,
    output logic      item_valid,
    output bwr_item_t item
);

    logic      valid_reg;
    logic      valid_next;
    bwr_item_t item_reg;
    logic      accept;

    assign in_ready   = !valid_reg || take;
    assign accept     = in_valid && in_ready;
    assign item_valid = valid_reg;
    assign item       = item_reg;

    always_comb
    begin
        if (accept)
        begin
            valid_next = 1'b1;
        end
        else if (take)
        begin
            valid_next = 1'b0;
        end
        else
        begin
            valid_next = valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            item_reg <= '{data_byte: data_byte, start_req: start_req};
        end
    end

endmodule

### design/bwr_repack_core.sv
// ----------------------------------------------------------------------------
// bwr_repack_core
// Repacking state and single-pass expand / compress logic
// ----------------------------------------------------------------------------
module bwr_repack_core
    import bwr_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  bwr_cfg_t    cfg,
    input  logic        item_valid,
    input  bwr_item_t   item,
    input  logic        buf_free,
    output logic        take,
    output logic        result_load,
    output bwr_result_t result
);

    logic [31:0] acc_reg, acc_next;
    logic [5:0]  held_reg, held_next;
    logic [2:0]  gpos_reg, gpos_next;
    logic [23:0] gval_reg, gval_next;

    logic [31:0] cur_acc;
    logic [5:0]  cur_held;
    logic [2:0]  cur_gpos;
    logic [23:0] cur_gval;

    logic [4:0]  fb;
    logic [2:0]  pad;
    logic [5:0]  fb_round;
    logic [1:0]  fw;
    logic [2:0]  width;
    logic [23:0] mask;

    // expand path
    logic [31:0] acc_x;
    logic [6:0]  held_x;
    logic        fire_x;
    logic [6:0]  held_e;
    logic [23:0] field;

    // compress path
    logic        in_field;
    logic [2:0]  gj;
    logic [7:0]  mbyte;
    logic [23:0] gval_c;
    logic        done_c;
    logic [31:0] acc_c;
    logic [6:0]  held_t;
    logic [3:0]  nfull;
    logic [2:0]  n_c;
    logic [6:0]  base;

    // shared window shifter
    logic [31:0] sh_src;
    logic [6:0]  sh_amt;
    logic [31:0] win;

    bwr_bytes_t  exp_bytes;
    bwr_bytes_t  cmp_bytes;
    logic [2:0]  count;

    assign cur_acc  = item.start_req ? 32'd0 : acc_reg;
    assign cur_held = item.start_req ? 6'd0  : held_reg;
    assign cur_gpos = item.start_req ? 3'd0  : gpos_reg;
    assign cur_gval = item.start_req ? 24'd0 : gval_reg;

    always_comb
    begin
        if (cfg.field_bits < FieldBitsMin)
        begin
            fb = FieldBitsMin;
        end
        else if (cfg.field_bits > FieldBitsMax)
        begin
            fb = FieldBitsMax;
        end
        else
        begin
            fb = cfg.field_bits;
        end
        pad = (cfg.pad_bytes > PadBytesMax) ? PadBytesMax : cfg.pad_bytes;
    end

    assign fb_round = {1'b0, fb} + 6'd7;
    assign fw       = fb_round[4:3];
    assign width    = {1'b0, fw} + pad;
    assign mask     = 24'hFF_FFFF >> (FieldBitsMax - fb);

    // expand
    assign acc_x  = {cur_acc[23:0], item.data_byte};
    assign held_x = {1'b0, cur_held} + 7'd8;
    assign fire_x = held_x >= {2'b00, fb};
    assign held_e = held_x - {2'b00, fb};

    // compress
    assign in_field = (cur_gpos >= pad) && (cur_gpos < width);
    assign gj       = width - cur_gpos - 3'd1;
    assign mbyte    = pick_byte({8'h00, mask}, gj) & item.data_byte;

    always_comb
    begin
        gval_c = cur_gval;
        if (in_field)
        begin
            case (gj)
                3'd0:    gval_c[7:0]   = cur_gval[7:0]   | mbyte;
                3'd1:    gval_c[15:8]  = cur_gval[15:8]  | mbyte;
                3'd2:    gval_c[23:16] = cur_gval[23:16] | mbyte;
                default: gval_c = cur_gval;
            endcase
        end
    end

    assign done_c = ({1'b0, cur_gpos} + 4'd1) >= {1'b0, width};
    assign acc_c  = (cur_acc << fb) | {8'h00, gval_c};
    assign held_t = {1'b0, cur_held} + {2'b00, fb};
    assign nfull  = held_t[6:3];
    assign n_c    = (nfull > 4'd7) ? 3'd7 : nfull[2:0];
    assign base   = held_t - {1'b0, n_c, 3'b000};

    assign sh_src = (cfg.mode == ModeCompress) ? acc_c : acc_x;
    assign sh_amt = (cfg.mode == ModeCompress) ? base : held_e;
    assign win    = (sh_amt >= 7'd32) ? 32'd0 : (sh_src >> sh_amt[4:0]);
    assign field  = win[23:0] & mask;

    for (genvar g = 0; g < MaxBytes; g++)
    begin : g_lane
        localparam logic [2:0] Pos = 3'(g);
        assign exp_bytes[g] = ((Pos < width) && (Pos >= pad))
                              ? pick_byte({8'h00, field}, width - 3'd1 - Pos) : 8'h00;
        assign cmp_bytes[g] = (Pos < n_c) ? pick_byte(win, n_c - 3'd1 - Pos) : 8'h00;
    end

    always_comb
    begin
        if (cfg.mode == ModeCompress)
        begin
            count = done_c ? n_c : 3'd0;
        end
        else
        begin
            count = fire_x ? width : 3'd0;
        end
    end

    assign take         = item_valid && ((count == 3'd0) || buf_free);
    assign result_load  = take && (count != 3'd0);
    assign result.bytes = (cfg.mode == ModeCompress) ? cmp_bytes : exp_bytes;
    assign result.count = count;

    always_comb
    begin
        acc_next  = acc_reg;
        held_next = held_reg;
        gpos_next = gpos_reg;
        gval_next = gval_reg;
        if (take)
        begin
            if (cfg.mode == ModeCompress)
            begin
                if (done_c)
                begin
                    acc_next  = acc_c;
                    held_next = base[5:0];
                    gpos_next = 3'd0;
                    gval_next = 24'd0;
                end
                else
                begin
                    acc_next  = cur_acc;
                    held_next = cur_held;
                    gpos_next = cur_gpos + 3'd1;
                    gval_next = gval_c;
                end
            end
            else
            begin
                acc_next  = acc_x;
                held_next = fire_x ? held_e[5:0] : held_x[5:0];
                gpos_next = cur_gpos;
                gval_next = cur_gval;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg  <= 32'd0;
            held_reg <= 6'd0;
            gpos_reg <= 3'd0;
            gval_reg <= 24'd0;
        end
        else
        begin
            acc_reg  <= acc_next;
            held_reg <= held_next;
            gpos_reg <= gpos_next;
            gval_reg <= gval_next;
        end
    end

endmodule

### design/bwr_out_buffer.sv
// ----------------------------------------------------------------------------
// bwr_out_buffer
// Result register that hands out one byte per transfer
// ----------------------------------------------------------------------------
module bwr_out_buffer
    import bwr_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        load,
    input  bwr_result_t result,
    output logic        buf_free,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [7:0]  out_byte,
    output logic        last
);

    bwr_bytes_t bytes_reg, bytes_next;
    logic [2:0] count_reg, count_next;
    logic       xfer;

    assign out_valid = count_reg != 3'd0;
    assign out_byte  = bytes_reg[0];
    assign last      = count_reg == 3'd1;
    assign xfer      = out_valid && out_ready;
    assign buf_free  = (count_reg == 3'd0) || (xfer && last);

    always_comb
    begin
        bytes_next = bytes_reg;
        count_next = count_reg;
        if (load)
        begin
            bytes_next = result.bytes;
            count_next = result.count;
        end
        else if (xfer)
        begin
            bytes_next = bytes_reg >> 8;
            count_next = count_reg - 3'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= 3'd0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        bytes_reg <= bytes_next;
    end

endmodule

### design/bit_width_repacker_unit.sv
// ----------------------------------------------------------------------------
// bit_width_repacker_unit
// Repacks a byte stream between packed bit fields and padded byte groups
//
//   channel   handshake             payload
//   in        in_valid / in_ready   data_byte, start_req
//   out       out_valid / out_ready out_byte, last
//   cfg       cfg_write             cfg_index, cfg_data
//
// an accepted byte is worked on the next cycle; its result (up to 7 bytes per
// byte) is loaded into the result register and sent one per cycle if out_ready
// a byte that completes a group waits until the previous group's last byte goes
// bytes that give no result pass at one per cycle
// reset sets configuration to its defaults and clears the repacking state
// an out_ready stall holds the result register and then the input behind it
// ----------------------------------------------------------------------------
module bit_width_repacker_unit
    import bwr_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    cfg_write,
    input  logic [1:0]              cfg_index,
    input  logic [CfgDataWidth-1:0] cfg_data,
    input  logic                    in_valid,
    output logic                    in_ready,
    input  logic [7:0]              data_byte,
    input  logic                    start_req,
    output logic                    out_valid,
    input  logic                    out_ready,
    output logic [7:0]              out_byte,
    output logic                    last
);

    bwr_cfg_t    cfg_reg, cfg_next;
    bwr_item_t   item;
    logic        item_valid;
    logic        take;
    logic        result_load;
    logic        buf_free;
    bwr_result_t result;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_write)
        begin
            case (bwr_reg_idx_t'(cfg_index))
                RegMode:      cfg_next.mode       = cfg_data[0];
                RegFieldBits: cfg_next.field_bits = cfg_data[4:0];
                RegPadBytes:  cfg_next.pad_bytes  = cfg_data[2:0];
                default:      cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '{mode: ModeReset, field_bits: FieldBitsReset,
                         pad_bytes: PadBytesReset};
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    bwr_input_stage u_input_stage (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .data_byte  (data_byte),
        .start_req  (start_req),
        .take       (take),
        .item_valid (item_valid),
        .item       (item)
    );

    bwr_repack_core u_repack_core (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg_reg),
        .item_valid  (item_valid),
        .item        (item),
        .buf_free    (buf_free),
        .take        (take),
        .result_load (result_load),
        .result      (result)
    );

    bwr_out_buffer u_out_buffer (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (result_load),
        .result    (result),
        .buf_free  (buf_free),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_byte  (out_byte),
        .last      (last)
    );

    // result register only reloaded once the previous group has gone
    assert property (@(posedge clk) disable iff (!rst_n)
        result_load |-> buf_free)
        else $error("result register overwritten while still holding bytes");

    // a stalled item waits in the input register unchanged
    assert property (@(posedge clk) disable iff (!rst_n)
        (item_valid && !take) |=> (item_valid && $stable(item)))
        else $error("input register lost a waiting item");

    // back-pressure on the input only while an item is waiting
    assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> item_valid)
        else $error("input stalled with empty input register");

    // after the final byte of a group the output goes quiet unless refilled
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_ready && last && !result_load) |=> !out_valid)
        else $error("output still valid after final byte transfer");

endmodule

### test/bit_width_repacker_unit_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bit_width_repacker_unit_tb
// Drives byte streams through the repacker in expand and compress layouts,
// under several register settings including out-of-range ones, and checks
// every output transfer against a cycle-free prediction of the repacking
// ----------------------------------------------------------------------------
module bit_width_repacker_unit_tb
    import bwr_pkg::*;
();

    typedef struct {
        logic [7:0] value;
        logic       last;
    } out_beat_t;

    class repack_scoreboard;
        out_beat_t   expected_bytes[$];
        int          errors;
        int          seen;
        logic        mode;
        logic [4:0]  field_bits;
        logic [2:0]  pad_bytes;
        logic [31:0] acc;
        logic [5:0]  held;
        logic [2:0]  grp_pos;
        logic [23:0] grp_val;

        function new();
            mode       = ModeReset;
            field_bits = FieldBitsReset;
            pad_bytes  = PadBytesReset;
            acc        = '0;
            held       = '0;
            grp_pos    = '0;
            grp_val    = '0;
            errors     = 0;
            seen       = 0;
        endfunction

        function void set_reg(bwr_reg_idx_t idx, logic [CfgDataWidth-1:0] val);
            case (idx)
                RegMode:      mode = val[0];
                RegFieldBits: field_bits = val[4:0];
                RegPadBytes:  pad_bytes = val[2:0];
                default:      ;
            endcase
        endfunction

        function logic [7:0] byte_of(logic [31:0] v, int unsigned sh);
            logic [31:0] t;
            if (sh >= 32)
            begin
                return 8'h00;
            end
            t = v >> sh;
            return t[7:0];
        endfunction

        function int pending();
            return expected_bytes.size();
        endfunction

        function void add_beat(out_beat_t beat);
            expected_bytes.insert(expected_bytes.size(), beat);
        endfunction

        // work out the output bytes caused by one accepted source byte
        function void take_source_byte(logic [7:0] d, logic s);
            int unsigned fb;
            int unsigned pad;
            int unsigned width;
            int unsigned h;
            int unsigned k;
            int unsigned x;
            int          n;
            logic [31:0] mask;
            logic [31:0] part;
            out_beat_t   beat;
            fb = (field_bits < FieldBitsMin) ? FieldBitsMin :
                 (field_bits > FieldBitsMax) ? FieldBitsMax : field_bits;
            pad = (pad_bytes > PadBytesMax) ? PadBytesMax : pad_bytes;
            width = (fb + 7) / 8 + pad;
            mask = (32'd1 << fb) - 32'd1;
            n = 0;
            if (s)
            begin
                acc     = '0;
                held    = '0;
                grp_pos = '0;
                grp_val = '0;
            end
            h = held;
            if (mode == ModeExpand)
            begin
                acc = {acc[23:0], d};
                h = h + 8;
                if (h >= fb)
                begin
                    h = h - fb;
                    for (x = 0; x < width; x++)
                    begin
                        beat.value = 8'h00;
                        beat.last  = 1'b0;
                        if (x >= pad)
                        begin
                            k = 8 * (width - x - 1);
                            beat.value = byte_of(acc, h + k) & byte_of(mask, k);
                        end
                        add_beat(beat);
                        n++;
                    end
                end
            end
            else
            begin
                x = grp_pos;
                if (x >= pad && x < width)
                begin
                    k = 8 * (width - x - 1);
                    part = ({24'd0, d} & {24'd0, byte_of(mask, k)}) << k;
                    grp_val = grp_val | part[23:0];
                end
                if (x + 1 >= width)
                begin
                    acc = (acc << fb) | {8'd0, grp_val};
                    h = h + fb;
                    grp_pos = '0;
                    grp_val = '0;
                    while (h >= 8 && n < MaxBytes)
                    begin
                        h = h - 8;
                        beat.value = byte_of(acc, h);
                        beat.last  = 1'b0;
                        add_beat(beat);
                        n++;
                    end
                end
                else
                begin
                    grp_pos = 3'(x + 1);
                end
            end
            held = 6'(h);
            if (n > 0)
            begin
                beat = expected_bytes[expected_bytes.size() - 1];
                beat.last = 1'b1;
                expected_bytes[expected_bytes.size() - 1] = beat;
            end
        endfunction

        task report_mismatch(string msg);
            errors++;
            $display("mismatch at output transfer %0d: %s", seen, msg);
        endtask

        task check_out_byte(logic [7:0] got_byte, logic got_last);
            out_beat_t want;
            seen++;
            if (expected_bytes.size() == 0)
            begin
                report_mismatch($sformatf("unexpected byte %02h last %b", got_byte, got_last));
            end
            else
            begin
                want = expected_bytes.pop_front();
                if (got_byte !== want.value)
                begin
                    report_mismatch($sformatf("out_byte %02h, want %02h", got_byte, want.value));
                end
                if (got_last !== want.last)
                begin
                    report_mismatch($sformatf("last %b, want %b", got_last, want.last));
                end
            end
        endtask
    endclass

    logic                    clk       = 1'b0;
    logic                    rst_n     = 1'b0;
    logic                    cfg_write = 1'b0;
    logic [1:0]              cfg_index = RegMode;
    logic [CfgDataWidth-1:0] cfg_data  = '0;
    logic                    in_valid  = 1'b0;
    logic                    in_ready;
    logic [7:0]              data_byte = 8'h00;
    logic                    start_req = 1'b0;
    logic                    out_valid;
    logic                    out_ready = 1'b0;
    logic [7:0]              out_byte;
    logic                    last;

    repack_scoreboard sb = new();
    bit               no_idle = 1'b0;
    int unsigned      stall_left = 0;

    bit_width_repacker_unit u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .data_byte (data_byte),
        .start_req (start_req),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_byte  (out_byte),
        .last      (last)
    );

    always #1 clk = ~clk;

    // output side: check each transfer, then drop out_ready at random
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            sb.check_out_byte(out_byte, last);
            stall_left = no_idle ? 0 : $urandom_range(0, 6);
        end
        if (stall_left > 0)
        begin
            out_ready <= 1'b0;
            stall_left--;
        end
        else
        begin
            out_ready <= 1'b1;
        end
    end

    task automatic send_byte(logic [7:0] d, logic s);
        int unsigned gap;
        gap = no_idle ? 0 : $urandom_range(0, 6);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid  <= 1'b1;
        data_byte <= d;
        start_req <= s;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        sb.take_source_byte(d, s);
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic write_config(logic m, logic [4:0] fb, logic [2:0] pad);
        cfg_write <= 1'b1;
        cfg_index <= RegMode;
        cfg_data  <= CfgDataWidth'(m);
        @(posedge clk);
        cfg_index <= RegFieldBits;
        cfg_data  <= CfgDataWidth'(fb);
        @(posedge clk);
        cfg_index <= RegPadBytes;
        cfg_data  <= CfgDataWidth'(pad);
        @(posedge clk);
        cfg_write <= 1'b0;
        sb.set_reg(RegMode, CfgDataWidth'(m));
        sb.set_reg(RegFieldBits, CfgDataWidth'(fb));
        sb.set_reg(RegPadBytes, CfgDataWidth'(pad));
    endtask

    initial
    begin
        #1_000_000;
        $display("*** FAILED ***");
        $finish;
    end

    initial
    begin
        logic       m;
        logic [4:0] fb;
        logic [2:0] pad;
        bit         restart;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset settings, expand 17 bits with one pad byte
        send_byte(8'hFF, 1'b1);
        send_byte(8'h00, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(8'h80, 1'b0);
        drain();

        // field width and pad above range, widest group
        write_config(ModeExpand, 5'd31, 3'd7);
        send_byte(8'hFF, 1'b1);
        send_byte(8'hFF, 1'b0);
        send_byte(8'hFF, 1'b0);
        drain();

        // field width below range, no padding, leftover bits kept
        write_config(ModeExpand, 5'd0, 3'd0);
        send_byte(8'h01, 1'b0);
        send_byte(8'hFE, 1'b0);
        drain();

        // mode change mid-stream, narrowest compress
        write_config(ModeCompress, FieldBitsMin, 3'd0);
        send_byte(8'hFF, 1'b0);
        send_byte(8'h00, 1'b1);
        drain();

        write_config(ModeCompress, FieldBitsMax, PadBytesMax);
        send_byte(8'hFF, 1'b1);
        for (int i = 0; i < 6; i++)
        begin
            send_byte(8'hFF, 1'b0);
        end
        send_byte(8'hA5, 1'b0);
        send_byte(8'h5A, 1'b0);
        send_byte(8'hC3, 1'b0);
        drain();

        // group position already past the new group width
        write_config(ModeCompress, FieldBitsMin, 3'd0);
        send_byte(8'h3C, 1'b0);
        drain();

        for (int p = 0; p < 8; p++)
        begin
            m = 1'($urandom_range(0, 1));
            fb = ($urandom_range(0, 3) == 0) ? 5'($urandom_range(0, 31))
                                             : 5'($urandom_range(8, 24));
            pad = ($urandom_range(0, 3) == 0) ? 3'($urandom_range(0, 7))
                                              : 3'($urandom_range(0, 4));
            restart = ($urandom_range(0, 3) != 0);
            no_idle = ($urandom_range(0, 3) == 0);
            write_config(m, fb, pad);
            for (int i = 0; i < 25; i++)
            begin
                send_byte(8'($urandom_range(0, 255)),
                          (i == 0 && restart) || ($urandom_range(0, 19) == 0));
            end
            drain();
        end

        if (sb.errors == 0)
        begin
            $display("*** PASSED ***");
        end
        else
        begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
